// File: design/s2a_pkg.sv
`default_nettype none

package s2a_pkg;

    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int TABLE_LEN  = 58;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [7:0] SC_PREFIX  = 8'hE0;
    localparam logic [7:0] SC_RELEASE = 8'h80;
    localparam logic [6:0] SC_KEYMASK = 7'h7F;
    localparam logic [6:0] SC_LSHIFT  = 7'h2A;
    localparam logic [6:0] SC_RSHIFT  = 7'h36;
    localparam logic [6:0] SC_CTRL    = 7'h1D;
    localparam logic [6:0] SC_CAPS    = 7'h3A;
    localparam logic [6:0] SC_PGUP    = 7'h49;
    localparam logic [6:0] SC_PGDN    = 7'h51;
    localparam logic [6:0] SC_UP      = 7'h48;
    localparam logic [6:0] SC_DOWN    = 7'h50;

    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    localparam logic [6:0] PLAIN_MAP [TABLE_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [6:0] SHIFT_MAP [TABLE_LEN] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [6:0] ch;
    } ring_req_t;

    typedef struct packed {
        logic       popped;
        logic [6:0] ch;
        logic       avail;
    } ring_stat_t;

    typedef struct packed {
        logic       push;
        logic [6:0] ch;
        logic [1:0] scroll;
    } key_out_t;

    function automatic logic [6:0] map_char(input logic [6:0] idx, input logic shifted);
        logic [6:0] ch;
        ch = 7'h00;
        if (idx < 7'(TABLE_LEN)) begin
            ch = shifted ? SHIFT_MAP[idx[5:0]] : PLAIN_MAP[idx[5:0]];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: design/s2a_keymap.sv
`default_nettype none

module s2a_keymap
    import s2a_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       feed_en,
    input  wire logic [7:0] scan_byte,
    output key_out_t        key_out
);

    logic shift_reg, ctrl_reg, caps_reg, prefix_reg;
    logic shift_next, ctrl_next, caps_next, prefix_next;
    logic [6:0] key;
    logic [6:0] base_ch;
    logic [6:0] ch;

    assign key = scan_byte[6:0] & SC_KEYMASK;

    always_comb begin
        base_ch = map_char(key, shift_reg);
        if (!shift_reg && caps_reg && base_ch inside {[7'h61:7'h7A]}) begin
            base_ch = base_ch - 7'h20;
        end
        ch = base_ch;
        if (ctrl_reg && (base_ch inside {[7'h61:7'h7A], [7'h41:7'h5A]})) begin
            ch = {2'b00, base_ch[4:0]};
        end
    end

    always_comb begin
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        caps_next   = caps_reg;
        prefix_next = prefix_reg;
        key_out     = '{push: 1'b0, ch: ch, scroll: SCROLL_NONE};
        if (scan_byte == SC_PREFIX) begin
            prefix_next = 1'b1;
        end else if ((scan_byte & SC_RELEASE) != 8'h00) begin
            if (key == SC_LSHIFT || key == SC_RSHIFT) begin
                shift_next = 1'b0;
            end
            if (key == SC_CTRL) begin
                ctrl_next = 1'b0;
            end
            prefix_next = 1'b0;
        end else if (prefix_reg) begin
            prefix_next = 1'b0;
            if (key == SC_PGUP || (key == SC_UP && ctrl_reg)) begin
                key_out.scroll = SCROLL_UP;
            end else if (key == SC_PGDN || (key == SC_DOWN && ctrl_reg)) begin
                key_out.scroll = SCROLL_DOWN;
            end
        end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
            shift_next = 1'b1;
        end else if (key == SC_CTRL) begin
            ctrl_next = 1'b1;
        end else if (key == SC_CAPS) begin
            caps_next = !caps_reg;
        end else begin
            key_out.push = (ch != 7'h00);
        end
        if (!feed_en) begin
            key_out.push   = 1'b0;
            key_out.scroll = SCROLL_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end else if (feed_en) begin
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

`default_nettype wire

// File: design/s2a_ring.sv
`default_nettype none

module s2a_ring
    import s2a_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire ring_req_t req,
    output ring_stat_t stat
);

    logic [6:0]       ring_mem [RING_DEPTH];
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_inc, wr_inc;
    logic             empty, full, push_ok, pop_ok;

    assign rd_inc  = (rd_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign wr_inc  = (wr_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign empty   = (rd_idx_reg == wr_idx_reg);
    assign full    = (wr_inc == rd_idx_reg);
    assign push_ok = req.push && !full;
    assign pop_ok  = req.pop && !empty;

    assign rd_idx_next = pop_ok  ? rd_inc : rd_idx_reg;
    assign wr_idx_next = push_ok ? wr_inc : wr_idx_reg;

    assign stat.popped = pop_ok;
    assign stat.ch     = pop_ok ? ring_mem[rd_idx_reg] : 7'h00;
    assign stat.avail  = (rd_idx_next != wr_idx_next);

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            ring_mem[wr_idx_reg] <= req.ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
        end else begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

endmodule

`default_nettype wire

// File: design/scancode_to_ascii_decoder.sv
// Path: input register, decode pass, then result register driving m_tdata.
// Throughput: 1 item per cycle while m_tready is high; input and result registers hold one item each.
// Keyboard flags and ring indices update in the single decode pass between the two.
// Reset: synchronous active-low aresetn clears flags, indices and both valid bits.
// Ring contents are not cleared; only written entries are ever read.
`default_nettype none

module scancode_to_ascii_decoder
    import s2a_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  wire logic        s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [6:0] char_out, [7] char_popped,
                                        // [8] chars_available, [10:9] scroll_request
);

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic       advance;
    key_out_t   key_out;
    ring_req_t  ring_req;
    ring_stat_t ring_stat;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    s2a_keymap u_keymap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .feed_en   (advance && in_op_reg == OP_FEED),
        .scan_byte (in_byte_reg),
        .key_out   (key_out)
    );

    assign ring_req.push = key_out.push;
    assign ring_req.pop  = advance && in_op_reg == OP_POP;
    assign ring_req.ch   = key_out.ch;

    s2a_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ring_req),
        .stat    (ring_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {5'b0, key_out.scroll, ring_stat.avail,
                             ring_stat.popped, ring_stat.ch};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: design/s2a_checker.sv
`default_nettype none

module s2a_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_popped_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> m_tdata[6:0] != 7'h00 && m_tdata[10:9] == 2'd0)
        else $error("popped transfer carries null char or scroll");

    a_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[7] |-> m_tdata[6:0] == 7'h00)
        else $error("char without pop");

    a_scroll_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:9] != 2'd3 && m_tdata[15:11] == 5'd0)
        else $error("bad scroll code or padding");

endmodule

bind scancode_to_ascii_decoder s2a_checker u_s2a_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
